// ===== rtl/core/scc_pkg.sv =====
// Shared types and widths for the swept circle collision pipeline.
`default_nettype none

package scc_pkg;

	// Field and register widths.
	localparam int FIELD_W = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_WRAP_ENABLE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_WORLD_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_WORLD_HEIGHT = 2'd2;

	// Unwrapped positions lie in [-65535, 65535].
	localparam int POS_W  = FIELD_W + 2;
	// Distances and per-step motion.
	localparam int DIFF_W = POS_W + 1;
	// Squares and cross terms of the differences.
	localparam int PRD_W  = 2 * DIFF_W;
	// Unsigned sums of squares; the signed closest approach term is one bit wider.
	localparam int SQ_W   = PRD_W;
	localparam int TOP_W  = SQ_W + 1;
	localparam int RSQ_W  = 2 * FIELD_W;
	// Wide products are built from half-width partial products.
	localparam int HALF_W = SQ_W / 2;
	localparam int PP_W   = 2 * HALF_W;
	localparam int WIDE_W = 2 * SQ_W;

	typedef struct packed {
		logic signed [POS_W-1:0] p1;
		logic signed [POS_W-1:0] p2;
		logic signed [POS_W-1:0] q1;
		logic signed [POS_W-1:0] q2;
	} axis_t;

	typedef struct packed {
		axis_t               x;
		axis_t               y;
		logic [FIELD_W-1:0]  radius;
	} pair_t;

	// Values handed from the term pipeline to the wide comparison.
	typedef struct packed {
		logic              early;
		logic              swept;
		logic [SQ_W-1:0]   excess;
		logic [SQ_W-1:0]   bot;
		logic [SQ_W-1:0]   tmag;
	} terms_t;

endpackage

`default_nettype wire

// ===== rtl/core/scc_unwrap.sv =====
// Two pipeline stages that unwrap both points on the torus before the distance test.
`default_nettype none

module scc_unwrap (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          wrap_enable,
	input  wire logic [15:0]   world_width,
	input  wire logic [15:0]   world_height,
	input  wire logic          src_valid,
	input  wire scc_pkg::pair_t src_item,
	output logic               res_valid,
	output scc_pkg::pair_t     res_item
);
	import scc_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] a1;
		logic signed [POS_W-1:0] a2;
		logic                    moved;
	} own_t;

	typedef struct packed {
		logic mpx;
		logic mqx;
		logic mpy;
		logic mqy;
	} move_t;

	// A point that moved more than half the world along an axis crossed the seam.
	function automatic own_t unwrap_own(input logic signed [POS_W-1:0] a1,
			input logic signed [POS_W-1:0] a2, input logic signed [POS_W-1:0] size,
			input logic wrap);
		own_t r;
		logic signed [POS_W-1:0] diff;
		logic signed [POS_W-1:0] mag;
		diff = a2 - a1;
		mag = diff[POS_W-1] ? -diff : diff;
		r.a1 = a1;
		r.a2 = a2;
		r.moved = wrap && (mag > (size >>> 1));
		if (r.moved) begin
			if (a1 > a2) begin
				r.a1 = a1 - size;
			end else begin
				r.a2 = a2 - size;
			end
		end
		return r;
	endfunction

	// When only one point crossed, the other one follows it to the same side.
	function automatic axis_t align(input axis_t a, input logic mp, input logic mq,
			input logic signed [POS_W-1:0] size);
		axis_t r;
		logic signed [POS_W-1:0] half;
		half = size >>> 1;
		r = a;
		if (mp && !mq && (($signed(a.q2) > half) || ($signed(a.q1) > half))) begin
			r.q1 = $signed(a.q1) - size;
			r.q2 = $signed(a.q2) - size;
		end
		if (mq && !mp && (($signed(a.p2) > half) || ($signed(a.p1) > half))) begin
			r.p1 = $signed(a.p1) - size;
			r.p2 = $signed(a.p2) - size;
		end
		return r;
	endfunction

	logic signed [POS_W-1:0] size_x;
	logic signed [POS_W-1:0] size_y;
	own_t  own_px, own_qx, own_py, own_qy;
	pair_t item_s1;
	move_t move_s1;
	logic  valid_s1;
	pair_t aligned;

	assign size_x = $signed({2'b00, world_width});
	assign size_y = $signed({2'b00, world_height});

	always_comb begin
		own_px = unwrap_own(src_item.x.p1, src_item.x.p2, size_x, wrap_enable);
		own_qx = unwrap_own(src_item.x.q1, src_item.x.q2, size_x, wrap_enable);
		own_py = unwrap_own(src_item.y.p1, src_item.y.p2, size_y, wrap_enable);
		own_qy = unwrap_own(src_item.y.q1, src_item.y.q2, size_y, wrap_enable);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.x.p1  <= own_px.a1;
			item_s1.x.p2  <= own_px.a2;
			item_s1.x.q1  <= own_qx.a1;
			item_s1.x.q2  <= own_qx.a2;
			item_s1.y.p1  <= own_py.a1;
			item_s1.y.p2  <= own_py.a2;
			item_s1.y.q1  <= own_qy.a1;
			item_s1.y.q2  <= own_qy.a2;
			item_s1.radius <= src_item.radius;
			move_s1.mpx   <= own_px.moved;
			move_s1.mqx   <= own_qx.moved;
			move_s1.mpy   <= own_py.moved;
			move_s1.mqy   <= own_qy.moved;
		end
	end

	always_comb begin
		aligned = item_s1;
		aligned.x = align(item_s1.x, move_s1.mpx, move_s1.mqx, size_x);
		aligned.y = align(item_s1.y, move_s1.mpy, move_s1.mqy, size_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_item <= aligned;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/scc_terms.sv =====
// Four pipeline stages that form the distance, motion and closest approach terms.
`default_nettype none

module scc_terms (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           src_valid,
	input  wire scc_pkg::pair_t src_item,
	output logic                res_valid,
	output scc_pkg::terms_t     res_terms
);
	import scc_pkg::*;

	function automatic logic signed [DIFF_W-1:0] widen(input logic [POS_W-1:0] v);
		return $signed({v[POS_W-1], v});
	endfunction

	function automatic logic signed [TOP_W-1:0] widen_prd(input logic [PRD_W-1:0] v);
		return $signed({v[PRD_W-1], v});
	endfunction

	// Stage 3: differences.
	logic signed [DIFF_W-1:0] dx_s3, dy_s3, f1_s3, f2_s3;
	logic [FIELD_W-1:0]       radius_s3;
	logic                     valid_s3;

	// Stage 4: products.
	logic signed [PRD_W-1:0]  dxx_s4, dyy_s4, fdx_s4, fdy_s4, ff1_s4, ff2_s4;
	logic [RSQ_W-1:0]         r2_s4;
	logic                     valid_s4;

	// Stage 5: sums.
	logic [SQ_W-1:0]          dist2_s5, bot_s5;
	logic signed [TOP_W-1:0]  top_s5;
	logic [RSQ_W-1:0]         r2_s5;
	logic                     valid_s5;

	logic [SQ_W-1:0]          r2_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			valid_s3  <= src_valid;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			res_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s3 <= widen(src_item.x.q2) - widen(src_item.x.p2);
			dy_s3 <= widen(src_item.y.q2) - widen(src_item.y.p2);
			f1_s3 <= (widen(src_item.x.p2) - widen(src_item.x.p1))
				- (widen(src_item.x.q2) - widen(src_item.x.q1));
			f2_s3 <= (widen(src_item.y.p2) - widen(src_item.y.p1))
				- (widen(src_item.y.q2) - widen(src_item.y.q1));
			radius_s3 <= src_item.radius;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxx_s4 <= dx_s3 * dx_s3;
			dyy_s4 <= dy_s3 * dy_s3;
			fdx_s4 <= f1_s3 * dx_s3;
			fdy_s4 <= f2_s3 * dy_s3;
			ff1_s4 <= f1_s3 * f1_s3;
			ff2_s4 <= f2_s3 * f2_s3;
			r2_s4  <= radius_s3 * radius_s3;
		end
	end

	// Squares are non-negative and small enough that their sum fits SQ_W bits.
	always_ff @(posedge clk) begin
		if (en) begin
			dist2_s5 <= SQ_W'(dxx_s4) + SQ_W'(dyy_s4);
			bot_s5   <= SQ_W'(ff1_s4) + SQ_W'(ff2_s4);
			top_s5   <= -(widen_prd(fdx_s4) + widen_prd(fdy_s4));
			r2_s5    <= r2_s4;
		end
	end

	assign r2_ext = {{(SQ_W-RSQ_W){1'b0}}, r2_s5};

	// The swept test needs the closest approach inside the step: 0 <= top <= bot.
	always_ff @(posedge clk) begin
		if (en) begin
			res_terms.early  <= dist2_s5 < r2_ext;
			res_terms.swept  <= !top_s5[TOP_W-1] && (bot_s5 != '0)
				&& (top_s5[SQ_W-1:0] <= bot_s5);
			res_terms.excess <= dist2_s5 - r2_ext;
			res_terms.bot    <= bot_s5;
			res_terms.tmag   <= top_s5[SQ_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/scc_wide_cmp.sv =====
// Three pipeline stages that compare (dist2 - r2) * bot against top squared.
`default_nettype none

module scc_wide_cmp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            src_valid,
	input  wire scc_pkg::terms_t src_terms,
	output logic                 res_valid,
	output logic                 res_hit
);
	import scc_pkg::*;

	logic [HALF_W-1:0] e_lo, e_hi, b_lo, b_hi, t_lo, t_hi;

	// Stage 7: partial products.
	logic [PP_W-1:0]   e_ll_s7, e_lh_s7, e_hl_s7, e_hh_s7;
	logic [PP_W-1:0]   t_ll_s7, t_lh_s7, t_hh_s7;
	logic              early_s7, swept_s7, valid_s7;

	// Stage 8: assembled products.
	logic [WIDE_W-1:0] lhs_s8, rhs_s8;
	logic              early_s8, swept_s8, valid_s8;

	assign e_lo = src_terms.excess[HALF_W-1:0];
	assign e_hi = src_terms.excess[SQ_W-1:HALF_W];
	assign b_lo = src_terms.bot[HALF_W-1:0];
	assign b_hi = src_terms.bot[SQ_W-1:HALF_W];
	assign t_lo = src_terms.tmag[HALF_W-1:0];
	assign t_hi = src_terms.tmag[SQ_W-1:HALF_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			valid_s7  <= src_valid;
			valid_s8  <= valid_s7;
			res_valid <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_ll_s7  <= e_lo * b_lo;
			e_lh_s7  <= e_lo * b_hi;
			e_hl_s7  <= e_hi * b_lo;
			e_hh_s7  <= e_hi * b_hi;
			t_ll_s7  <= t_lo * t_lo;
			t_lh_s7  <= t_lo * t_hi;
			t_hh_s7  <= t_hi * t_hi;
			early_s7 <= src_terms.early;
			swept_s7 <= src_terms.swept;
		end
	end

	// The cross term of a square appears twice, hence the extra shift by one.
	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s8 <= WIDE_W'(e_ll_s7)
				+ ((WIDE_W'(e_lh_s7) + WIDE_W'(e_hl_s7)) << HALF_W)
				+ (WIDE_W'(e_hh_s7) << SQ_W);
			rhs_s8 <= WIDE_W'(t_ll_s7)
				+ (WIDE_W'(t_lh_s7) << (HALF_W + 1))
				+ (WIDE_W'(t_hh_s7) << SQ_W);
			early_s8 <= early_s7;
			swept_s8 <= swept_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_hit <= early_s8 || (swept_s8 && (lhs_s8 < rhs_s8));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/swept_circle_collision_test.sv =====
// Top level of the swept circle collision test: configuration, pipeline and output skid.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------------
//   input    | in_valid / in_ready      | first_*, second_* coordinates, hit_radius
//   output   | out_valid / out_ready    | hit
//   config   | cfg_we                   | cfg_index, cfg_data
//
// One transaction is accepted per cycle while the skid register is empty; each result passes
// through the unwrap, term and wide-compare pipelines in turn.
// Reset clears the configuration to wrap off and world size 65535, and empties the pipe.
// A one-entry skid register holds a result the consumer refuses; while it is full
// the whole pipeline holds and in_ready is low, so nothing is lost or repeated.
`default_nettype none

module swept_circle_collision_test #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [scc_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [scc_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [scc_pkg::FIELD_W-1:0] first_prev_x,
	input  wire logic [scc_pkg::FIELD_W-1:0] first_prev_y,
	input  wire logic [scc_pkg::FIELD_W-1:0] first_now_x,
	input  wire logic [scc_pkg::FIELD_W-1:0] first_now_y,
	input  wire logic [scc_pkg::FIELD_W-1:0] second_prev_x,
	input  wire logic [scc_pkg::FIELD_W-1:0] second_prev_y,
	input  wire logic [scc_pkg::FIELD_W-1:0] second_now_x,
	input  wire logic [scc_pkg::FIELD_W-1:0] second_now_y,
	input  wire logic [scc_pkg::FIELD_W-1:0] hit_radius,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             hit
);
	import scc_pkg::*;

	// Coordinates keep only their low COORD_BITS bits.
	localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] COORD_MASK = FIELD_W'((64'd1 << CW) - 64'd1);

	function automatic logic signed [POS_W-1:0] coord(input logic [FIELD_W-1:0] v);
		return $signed({2'b00, v & COORD_MASK});
	endfunction

	logic               wrap_enable_q;
	logic [CFG_W-1:0]   world_width_q;
	logic [CFG_W-1:0]   world_height_q;

	logic               en;
	pair_t              src_item;
	logic               valid_s2;
	pair_t              item_s2;
	logic               valid_s6;
	terms_t             terms_s6;
	logic               valid_s9;
	logic               hit_s9;
	logic               skid_full_q;
	logic               skid_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_enable_q  <= 1'b0;
			world_width_q  <= 16'hFFFF;
			world_height_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WRAP_ENABLE:  wrap_enable_q  <= cfg_data[0];
				REG_WORLD_WIDTH:  world_width_q  <= cfg_data;
				REG_WORLD_HEIGHT: world_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		src_item.x.p1  = coord(first_prev_x);
		src_item.x.p2  = coord(first_now_x);
		src_item.x.q1  = coord(second_prev_x);
		src_item.x.q2  = coord(second_now_x);
		src_item.y.p1  = coord(first_prev_y);
		src_item.y.p2  = coord(first_now_y);
		src_item.y.q1  = coord(second_prev_y);
		src_item.y.q2  = coord(second_now_y);
		src_item.radius = hit_radius;
	end

	// The pipeline moves whenever the skid register is empty.
	assign en       = !skid_full_q;
	assign in_ready = en;

	scc_unwrap u_unwrap (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.wrap_enable  (wrap_enable_q),
		.world_width  (world_width_q),
		.world_height (world_height_q),
		.src_valid    (in_valid),
		.src_item     (src_item),
		.res_valid    (valid_s2),
		.res_item     (item_s2)
	);

	scc_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (valid_s2),
		.src_item  (item_s2),
		.res_valid (valid_s6),
		.res_terms (terms_s6)
	);

	scc_wide_cmp u_wide_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (valid_s6),
		.src_terms (terms_s6),
		.res_valid (valid_s9),
		.res_hit   (hit_s9)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (valid_s9 && !out_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && valid_s9 && !out_ready) begin
			skid_hit_q <= hit_s9;
		end
	end

	assign out_valid = skid_full_q || valid_s9;
	assign hit       = skid_full_q ? skid_hit_q : hit_s9;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the swept circle collision test block.
`timescale 1ns / 100ps

module tb;
	import scc_pkg::*;

	localparam int PIPE_DEPTH  = 9;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 82;
	localparam int N_PHASES    = 8;
	localparam int N_DIRECTED  = 22;

	typedef enum logic [1:0] {WORLD_PLAIN, WORLD_TORUS, WORLD_SMALL, WORLD_NONE} world_sel_e;
	typedef enum logic [1:0] {WANT_MISS, WANT_HIT, WANT_MODEL} want_e;

	typedef struct packed {
		logic [FIELD_W-1:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y, radius;
	} pair_in_t;

	typedef struct packed {
		world_sel_e world;
		pair_in_t   pair;
		want_e      want;
	} dir_row_t;

	typedef struct packed {
		longint p1, p2, q1, q2;
	} axis_pos_t;

	typedef struct {
		bit hit;
		int tag;
	} hit_expect_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	pair_in_t           pair_drv  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               hit;

	// Copy of the configuration as the block should hold it.
	bit                 model_wrap = 1'b0;
	logic [FIELD_W-1:0] model_ww   = 16'hFFFF;
	logic [FIELD_W-1:0] model_wh   = 16'hFFFF;

	int                 send_idle_pct  = 0;
	int                 stall_pct      = 0;
	int                 mismatch_count = 0;
	int                 accepted_items = 0;
	int                 quiet_cycles   = 0;
	world_sel_e         cur_world      = WORLD_PLAIN;
	hit_expect_t        hit_queue[$];

	dir_row_t dir_rows [N_DIRECTED] = '{
		{WORLD_PLAIN, 16'd0, 16'd0, 16'd0, 16'd0,
		 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, WANT_MISS},
		{WORLD_PLAIN, 16'd0, 16'd0, 16'd0, 16'd0,
		 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, WANT_HIT},
		{WORLD_PLAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, WANT_HIT},
		{WORLD_PLAIN, 16'd0, 16'd0, 16'd0, 16'd0,
		 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, WANT_MISS},
		// Distance exactly equal to the radius is not a hit.
		{WORLD_PLAIN, 16'd0, 16'd0, 16'd0, 16'd0,
		 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, WANT_MISS},
		{WORLD_PLAIN, 16'd0, 16'd0, 16'd0, 16'd0,
		 16'd65534, 16'd0, 16'd65534, 16'd0, 16'hFFFF, WANT_HIT},
		// Same motion for both points leaves no relative motion.
		{WORLD_PLAIN, 16'd0, 16'd0, 16'd100, 16'd100,
		 16'd50, 16'd0, 16'd150, 16'd100, 16'd50, WANT_MISS},
		// Closest approach lies outside the step, on either side.
		{WORLD_PLAIN, 16'd0, 16'd100, 16'd100, 16'd100,
		 16'd1000, 16'd100, 16'd900, 16'd100, 16'd50, WANT_MISS},
		{WORLD_PLAIN, 16'd100, 16'd100, 16'd0, 16'd100,
		 16'd200, 16'd100, 16'd300, 16'd100, 16'd50, WANT_MISS},
		{WORLD_PLAIN, 16'd0, 16'd100, 16'd2000, 16'd100,
		 16'd1000, 16'd110, 16'd1000, 16'd110, 16'd20, WANT_MODEL},
		{WORLD_PLAIN, 16'd0, 16'd100, 16'd2000, 16'd100,
		 16'd1000, 16'd130, 16'd1000, 16'd130, 16'd20, WANT_MODEL},
		{WORLD_PLAIN, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
		 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1, WANT_MODEL},
		{WORLD_PLAIN, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
		 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, WANT_MODEL},
		{WORLD_TORUS, 16'd65530, 16'd100, 16'd3, 16'd100,
		 16'd1, 16'd100, 16'd1, 16'd100, 16'd1, WANT_MODEL},
		{WORLD_TORUS, 16'd60000, 16'd60000, 16'd60000, 16'd60000,
		 16'd65000, 16'd60000, 16'd100, 16'd60000, 16'd10, WANT_MODEL},
		{WORLD_TORUS, 16'd100, 16'd65530, 16'd100, 16'd3,
		 16'd100, 16'd40000, 16'd100, 16'd40000, 16'd5, WANT_MODEL},
		{WORLD_TORUS, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
		 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, WANT_MODEL},
		{WORLD_SMALL, 16'd990, 16'd690, 16'd5, 16'd5,
		 16'd2, 16'd2, 16'd2, 16'd2, 16'd3, WANT_MODEL},
		{WORLD_SMALL, 16'hFFFF, 16'd0, 16'd0, 16'd0,
		 16'd500, 16'd350, 16'd999, 16'd699, 16'd100, WANT_MODEL},
		// A zero world size turns every unwrap shift into a shift by zero.
		{WORLD_NONE, 16'd65530, 16'd100, 16'd3, 16'd100,
		 16'd1, 16'd100, 16'd1, 16'd100, 16'd1, WANT_MODEL},
		{WORLD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, WANT_HIT},
		{WORLD_PLAIN, 16'd12345, 16'd54321, 16'd40000, 16'd1000,
		 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, WANT_MODEL}
	};

	swept_circle_collision_test dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_prev_x  (pair_drv.p1x),
		.first_prev_y  (pair_drv.p1y),
		.first_now_x   (pair_drv.p2x),
		.first_now_y   (pair_drv.p2y),
		.second_prev_x (pair_drv.q1x),
		.second_prev_y (pair_drv.q1y),
		.second_now_x  (pair_drv.q2x),
		.second_now_y  (pair_drv.q2y),
		.hit_radius    (pair_drv.radius),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Unwrap one axis of both points on a torus of the given size.
	function automatic axis_pos_t align_axis(axis_pos_t a, longint size);
		longint half;
		bit     mp, mq;
		half = size / 2;
		mp = ((a.p2 > a.p1) ? a.p2 - a.p1 : a.p1 - a.p2) > half;
		if (mp) begin
			if (a.p1 > a.p2)
				a.p1 -= size;
			else
				a.p2 -= size;
		end
		mq = ((a.q2 > a.q1) ? a.q2 - a.q1 : a.q1 - a.q2) > half;
		if (mq) begin
			if (a.q1 > a.q2)
				a.q1 -= size;
			else
				a.q2 -= size;
		end
		// A point that did not cross the seam follows the one that did.
		if (mp && !mq && (a.q2 > half || a.q1 > half)) begin
			a.q1 -= size;
			a.q2 -= size;
		end
		if (mq && !mp && (a.p2 > half || a.p1 > half)) begin
			a.p1 -= size;
			a.p2 -= size;
		end
		return a;
	endfunction

	function automatic bit predict_hit(pair_in_t item);
		axis_pos_t         ax, ay;
		longint            dx, dy, f1, f2, top, bot, dist2, rad2;
		logic signed [127:0] lhs, rhs;
		ax.p1 = item.p1x;
		ax.p2 = item.p2x;
		ax.q1 = item.q1x;
		ax.q2 = item.q2x;
		ay.p1 = item.p1y;
		ay.p2 = item.p2y;
		ay.q1 = item.q1y;
		ay.q2 = item.q2y;
		if (model_wrap) begin
			ax = align_axis(ax, longint'(model_ww));
			ay = align_axis(ay, longint'(model_wh));
		end
		dx = ax.q2 - ax.p2;
		dy = ay.q2 - ay.p2;
		dist2 = dx * dx + dy * dy;
		rad2 = longint'(item.radius) * longint'(item.radius);
		if (dist2 < rad2)
			return 1'b1;
		f1 = (ax.p2 - ax.p1) - (ax.q2 - ax.q1);
		f2 = (ay.p2 - ay.p1) - (ay.q2 - ay.q1);
		top = -(f1 * dx + f2 * dy);
		bot = f1 * f1 + f2 * f2;
		if (top < 0 || bot < 1 || top > bot)
			return 1'b0;
		// Distance at the closest approach against the radius, without a division.
		lhs = 128'(dist2 - rad2) * 128'(bot);
		rhs = 128'(top) * 128'(top);
		return lhs < rhs;
	endfunction

	// Coordinate near a center; folded into the world when wrapping, else clamped.
	function automatic logic [FIELD_W-1:0] near_coord(int center, int spread, int size);
		int v;
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (size > 0)
			v = ((v % size) + size) % size;
		else if (v < 0)
			v = 0;
		else if (v > 65535)
			v = 65535;
		return v[FIELD_W-1:0];
	endfunction

	function automatic pair_in_t random_pair();
		pair_in_t item;
		int       sx, sy, sp, kind;
		sx = model_wrap ? int'(model_ww) : 0;
		sy = model_wrap ? int'(model_wh) : 0;
		kind = $urandom_range(9);
		case ($urandom_range(3))
			0: sp = 3;
			1: sp = 60;
			2: sp = 1500;
			default: sp = 30000;
		endcase
		if (kind < 2) begin
			for (int k = 0; k < 9; k++)
				item[k * FIELD_W +: FIELD_W] = FIELD_W'($urandom);
		end else begin
			item.p1x = near_coord($urandom_range(65535), 0, sx);
			item.p1y = near_coord($urandom_range(65535), 0, sy);
			item.p2x = near_coord(item.p1x, sp, sx);
			item.p2y = near_coord(item.p1y, sp, sy);
			if (kind == 2) begin
				// Both points share one motion, so only the current distance counts.
				item.q1x = near_coord(item.p1x, sp, sx);
				item.q1y = near_coord(item.p1y, sp, sy);
				item.q2x = near_coord(int'(item.q1x) + int'(item.p2x) - int'(item.p1x), 0, sx);
				item.q2y = near_coord(int'(item.q1y) + int'(item.p2y) - int'(item.p1y), 0, sy);
			end else begin
				// The second point runs against the first, so the paths tend to cross.
				item.q1x = near_coord(item.p2x, sp, sx);
				item.q1y = near_coord(item.p2y, sp, sy);
				item.q2x = near_coord(item.p1x, sp, sx);
				item.q2y = near_coord(item.p1y, sp, sy);
			end
			item.radius = (kind == 9) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(sp));
		end
		return item;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic send_pair(input pair_in_t item, input want_e want);
		hit_expect_t entry;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pair_drv <= item;
		do @(posedge clk); while (in_ready !== 1'b1);
		entry.hit = (want == WANT_MODEL) ? predict_hit(item) : (want == WANT_HIT);
		entry.tag = accepted_items;
		accepted_items++;
		hit_queue.push_back(entry);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (hit_queue.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_world(input bit wrap_on, input logic [FIELD_W-1:0] width,
			input logic [FIELD_W-1:0] height);
		settle();
		write_reg(REG_WRAP_ENABLE, CFG_W'(wrap_on));
		write_reg(REG_WORLD_WIDTH, width);
		write_reg(REG_WORLD_HEIGHT, height);
		cfg_we <= 1'b0;
		model_wrap = wrap_on;
		model_ww = width;
		model_wh = height;
	endtask

	always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		hit_expect_t head;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (hit_queue.size() == 0) begin
				report_mismatch($sformatf("result hit=%0b with no transaction outstanding", hit));
			end else begin
				head = hit_queue.pop_front();
				if (hit !== head.hit)
					report_mismatch($sformatf("transaction %0d: hit=%0b, predicted %0b",
						head.tag, hit, head.hit));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIRECTED; r++) begin
			if (dir_rows[r].world != cur_world) begin
				case (dir_rows[r].world)
					WORLD_PLAIN: set_world(1'b0, 16'hFFFF, 16'hFFFF);
					WORLD_TORUS: set_world(1'b1, 16'hFFFF, 16'hFFFF);
					WORLD_SMALL: set_world(1'b1, 16'd1000, 16'd700);
					default:     set_world(1'b1, 16'd0, 16'd0);
				endcase
				cur_world = dir_rows[r].world;
			end
			send_pair(dir_rows[r].pair, dir_rows[r].want);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: set_world(1'b0, 16'hFFFF, 16'hFFFF);
				1: set_world(1'b1, 16'hFFFF, 16'hFFFF);
				2: set_world(1'b1, 16'd1000, 16'd700);
				3: set_world(1'b1, 16'd1, 16'd1);
				4: set_world(1'b1, FIELD_W'($urandom_range(65535, 1)),
					FIELD_W'($urandom_range(65535, 1)));
				5: set_world(1'b1, 16'd64, 16'd40000);
				6: set_world(1'b0, 16'd300, 16'd300);
				default: set_world(1'b1, FIELD_W'($urandom_range(4096, 2)),
					FIELD_W'($urandom_range(4096, 2)));
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 84;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 84;
				end
				default: begin
					send_idle_pct = 29;
					stall_pct = 29;
				end
			endcase
			repeat (PHASE_ITEMS) send_pair(random_pair(), WANT_MODEL);
		end

		settle();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
